// ===== hw/rtl/bpa_pkg.sv =====
// Shared types, constants and helper functions for the bitmap page allocator.
// Used by the controller, the datapath and the top level.
// No dependencies.
package bpa_pkg;

  // Field widths of the stream items and the configuration register.
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned PAGE_W    = 14;   // wide enough for page_index + page_count
  localparam int unsigned WORD_W    = 32;   // pages held in one bitmap row
  localparam int unsigned WORD_BITS = 5;    // log2 of WORD_W
  localparam int unsigned ROW_W     = PAGE_W - WORD_BITS;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic [CNT_W-1:0] CNT_MAX     = '1;
  localparam int unsigned      TOTAL_RST   = 32'h1000;
  localparam int unsigned      STORE_LIMIT = 8192;

  // Register select on paddr[2]: total_pages is the only register.
  localparam logic REG_TOTAL_PAGES = 1'b0;

  // Item kinds; the remaining codes are undefined and change nothing.
  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC     = 3'd0,
    KIND_FREE      = 3'd1,
    KIND_LOCK      = 3'd2,
    KIND_RESERVE   = 3'd3,
    KIND_UNRESERVE = 3'd4
  } kind_e;

  // Controller states, one-hot.
  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_PREP  = 6'b000100,
    S_READ  = 6'b001000,
    S_MOD   = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic prep;
    logic rd;
    logic modify;
    logic clr;
    logic out_load;
  } bpa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;      // item needs no bitmap access
    logic finish;     // the row being modified completes the item
    logic clr_last;   // clearing pass is at its last row
  } bpa_stat_t;

  // Index of the lowest set bit of a row.
  function automatic logic [WORD_BITS-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [WORD_BITS-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = WORD_BITS'(i);
      end
    end
    return r;
  endfunction

  // Counter raised by n, held at its top value.
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                               input logic [WORD_BITS:0] n);
    logic [CNT_W:0] s;
    s = {1'b0, c} + (CNT_W + 1)'(n);
    return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  // Counter lowered by n, held at zero.
  function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] c,
                                               input logic [WORD_BITS:0] n);
    return (c > CNT_W'(n)) ? (c - CNT_W'(n)) : '0;
  endfunction

endpackage

// ===== hw/rtl/bpa_ctrl.sv =====
// Controller state machine of the bitmap page allocator.
// Sequences clearing, row reads and row updates; owns the handshakes.
// Depends on bpa_pkg.
module bpa_ctrl
  import bpa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  logic      cfg_wr_i,
  input  bpa_stat_t stat_i,
  output bpa_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  // Handshake terms.
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;

  // Commands decoded from the state.
  always_comb begin
    cmd_o           = '0;
    cmd_o.load_item = accept;
    cmd_o.prep      = (state_q == S_PREP);
    cmd_o.rd        = (state_q == S_READ);
    cmd_o.modify    = (state_q == S_MOD);
    cmd_o.clr       = (state_q == S_CLEAR);
    cmd_o.out_load  = (state_q == S_DONE) & out_free;
  end

  // Next state; a register write always restarts the clearing pass.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_d = S_PREP;
      end
      S_PREP: begin
        state_d = stat_i.empty ? S_DONE : S_READ;
      end
      S_READ: begin
        state_d = S_MOD;
      end
      S_MOD: begin
        state_d = stat_i.finish ? S_DONE : S_READ;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
    if (cfg_wr_i) state_d = S_CLEAR;
  end

  // Output valid flag: set when a result is loaded, cleared when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // An accepted item is prepared in the following cycle.
  a_accept_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_wr_i) |=> (state_q == S_PREP))
    else $error("accepted item was not prepared");

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending result");

  // A register write sends the block into the clearing pass.
  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr_i |=> (state_q == S_CLEAR && !in_ready_o))
    else $error("register write did not start the clearing pass");

endmodule

// ===== hw/rtl/bpa_dp.sv =====
// Datapath of the bitmap page allocator: bitmap memory, hint, counters,
// configuration register and result register.
// Depends on bpa_pkg; driven by bpa_ctrl through bpa_cmd_t.
module bpa_dp
  import bpa_pkg::*;
#(
  parameter int unsigned MAX_PAGES = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bpa_cmd_t          cmd_i,
  output bpa_stat_t         stat_o,
  input  logic              cfg_wr_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  output logic [CNT_W-1:0]  total_o,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [IDX_W-1:0]  page_index_i,
  input  logic [CNT_W-1:0]  page_count_i,
  output logic [IDX_W-1:0]  alloc_page_o,
  output logic              alloc_ok_o,
  output logic [CNT_W-1:0]  free_pages_o,
  output logic [CNT_W-1:0]  used_pages_o,
  output logic [CNT_W-1:0]  reserved_pages_o
);

  // Pages beyond what the 13-bit limit can reach are never stored.
  localparam int unsigned STORE_PAGES = (MAX_PAGES > STORE_LIMIT) ? STORE_LIMIT : MAX_PAGES;
  localparam int unsigned ROWS        = (STORE_PAGES + WORD_W - 1) / WORD_W;
  localparam int unsigned RAW         = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned LIM_CAP     = (MAX_PAGES > 8191) ? 8191 : MAX_PAGES;
  localparam int unsigned FREE_RST    = (MAX_PAGES < TOTAL_RST) ? MAX_PAGES : TOTAL_RST;
  localparam logic [CNT_W-1:0] LIM_MAX = CNT_W'(LIM_CAP);
  localparam logic [WORD_W-1:0] ONES   = '1;

  // Bitmap memory and its registered read port.
  logic [WORD_W-1:0] page_mem_q [ROWS];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_we;
  logic [RAW-1:0]    mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  // Architectural state.
  logic [CNT_W-1:0] total_q, hint_q, free_q, used_q, rsv_q;
  logic [RAW-1:0]   clr_row_q;

  // Item being worked on.
  logic [KIND_W-1:0]    kind_q;
  logic [IDX_W-1:0]     first_q;
  logic [PAGE_W-1:0]    end_q;
  logic [ROW_W-1:0]     row_q, first_row_q, last_row_q;
  logic [WORD_BITS-1:0] lo_bit_q, hi_bit_q;
  logic [IDX_W-1:0]     page_q;
  logic                 ok_q;

  // Result register.
  logic [IDX_W-1:0] out_page_q;
  logic             out_ok_q;
  logic [CNT_W-1:0] out_free_q, out_used_q, out_rsv_q;

  // Limit and item classification.
  logic [CNT_W-1:0]  lim, lim_m1, new_lim;
  logic [PAGE_W-1:0] stop_w, stop_m1;
  logic              is_alloc, is_run, is_set;

  assign lim     = (total_q > LIM_MAX) ? LIM_MAX : total_q;
  assign new_lim = (cfg_wdata_i > LIM_MAX) ? LIM_MAX : cfg_wdata_i;
  assign lim_m1  = lim - CNT_W'(1);
  assign stop_w  = (end_q > PAGE_W'(lim)) ? PAGE_W'(lim) : end_q;
  assign stop_m1 = stop_w - PAGE_W'(1);

  assign is_alloc = (kind_q == KIND_ALLOC);
  assign is_run   = (kind_q == KIND_FREE) || (kind_q == KIND_LOCK) ||
                    (kind_q == KIND_RESERVE) || (kind_q == KIND_UNRESERVE);
  assign is_set   = (kind_q == KIND_LOCK) || (kind_q == KIND_RESERVE);

  // Row update: in-range mask, changed bits and the new row value.
  logic [WORD_W-1:0]    lo_mask, hi_mask, row_mask, alloc_cand, chg, new_row;
  logic [WORD_BITS-1:0] low_bit;
  logic [WORD_BITS:0]   n_chg;
  logic [PAGE_W-1:0]    hit_page;
  logic                 found, last_row;

  always_comb begin
    lo_mask    = (row_q == first_row_q) ? (ONES << lo_bit_q) : ONES;
    hi_mask    = (row_q == last_row_q) ?
                 (ONES >> (WORD_BITS'(WORD_W - 1) - hi_bit_q)) : ONES;
    row_mask   = lo_mask & hi_mask;
    alloc_cand = ~rdata_q & row_mask;
    chg        = row_mask & (is_set ? ~rdata_q : rdata_q);
    low_bit    = lowest_set(is_alloc ? alloc_cand : chg);
    found      = |alloc_cand;
    n_chg      = (WORD_BITS + 1)'($countones(chg));
    hit_page   = {row_q, low_bit};
    last_row   = (row_q == last_row_q);
    if (is_alloc) begin
      new_row = rdata_q | (ONES[WORD_W-1:0] & (WORD_W'(1) << low_bit));
    end else if (is_set) begin
      new_row = rdata_q | chg;
    end else begin
      new_row = rdata_q & ~chg;
    end
  end

  // Status back to the controller.
  always_comb begin
    stat_o.empty    = is_alloc ? (hint_q >= lim) :
                      (is_run ? (stop_w <= PAGE_W'(first_q)) : 1'b1);
    stat_o.finish   = last_row | (is_alloc & found);
    stat_o.clr_last = (clr_row_q == RAW'(ROWS - 1));
  end

  // Memory write port: clearing pass or row update.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = RAW'(row_q);
    mem_wdata = new_row;
    if (cmd_i.clr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_row_q;
      mem_wdata = '0;
    end else if (cmd_i.modify) begin
      mem_we    = is_alloc ? found : 1'b1;
    end
  end

  // Bitmap storage, one row written and one row read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      page_mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= page_mem_q[RAW'(row_q)];
    end
  end

  // Item registers, search bounds and per-item result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q  <= kind_i;
      first_q <= page_index_i;
      end_q   <= PAGE_W'(page_index_i) + PAGE_W'(page_count_i);
    end
    if (cmd_i.prep) begin
      page_q <= '0;
      ok_q   <= is_run;
      if (is_alloc) begin
        row_q       <= ROW_W'(hint_q >> WORD_BITS);
        first_row_q <= ROW_W'(hint_q >> WORD_BITS);
        last_row_q  <= ROW_W'(lim_m1 >> WORD_BITS);
        lo_bit_q    <= hint_q[WORD_BITS-1:0];
        hi_bit_q    <= lim_m1[WORD_BITS-1:0];
      end else begin
        row_q       <= ROW_W'(first_q >> WORD_BITS);
        first_row_q <= ROW_W'(first_q >> WORD_BITS);
        last_row_q  <= stop_m1[PAGE_W-1:WORD_BITS];
        lo_bit_q    <= first_q[WORD_BITS-1:0];
        hi_bit_q    <= stop_m1[WORD_BITS-1:0];
      end
    end
    if (cmd_i.modify) begin
      if (!stat_o.finish) begin
        row_q <= row_q + ROW_W'(1);
      end
      if (is_alloc && found) begin
        page_q <= hit_page[IDX_W-1:0];
        ok_q   <= 1'b1;
      end
    end
  end

  // Hint, counters, limit register and clearing row.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= CNT_W'(TOTAL_RST);
      hint_q    <= '0;
      free_q    <= CNT_W'(FREE_RST);
      used_q    <= '0;
      rsv_q     <= '0;
      clr_row_q <= '0;
    end else if (cfg_wr_i) begin
      total_q   <= cfg_wdata_i;
      hint_q    <= '0;
      free_q    <= new_lim;
      used_q    <= '0;
      rsv_q     <= '0;
      clr_row_q <= '0;
    end else begin
      if (cmd_i.clr && !stat_o.clr_last) begin
        clr_row_q <= clr_row_q + RAW'(1);
      end
      if (cmd_i.modify) begin
        if (is_alloc) begin
          if (found) begin
            hint_q <= hit_page[CNT_W-1:0];
            free_q <= sat_sub(free_q, (WORD_BITS + 1)'(1));
            used_q <= sat_add(used_q, (WORD_BITS + 1)'(1));
          end else if (last_row) begin
            hint_q <= lim;
          end
        end else begin
          case (kind_q)
            KIND_FREE: begin
              free_q <= sat_add(free_q, n_chg);
              used_q <= sat_sub(used_q, n_chg);
              if ((|chg) && (hit_page < PAGE_W'(hint_q))) begin
                hint_q <= hit_page[CNT_W-1:0];
              end
            end
            KIND_UNRESERVE: begin
              free_q <= sat_add(free_q, n_chg);
              rsv_q  <= sat_sub(rsv_q, n_chg);
            end
            KIND_LOCK: begin
              free_q <= sat_sub(free_q, n_chg);
              used_q <= sat_add(used_q, n_chg);
            end
            KIND_RESERVE: begin
              free_q <= sat_sub(free_q, n_chg);
              rsv_q  <= sat_add(rsv_q, n_chg);
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  // Result register, held until the downstream side takes the item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_page_q <= page_q;
      out_ok_q   <= ok_q;
      out_free_q <= free_q;
      out_used_q <= used_q;
      out_rsv_q  <= rsv_q;
    end
  end

  assign total_o          = total_q;
  assign alloc_page_o     = out_page_q;
  assign alloc_ok_o       = out_ok_q;
  assign free_pages_o     = out_free_q;
  assign used_pages_o     = out_used_q;
  assign reserved_pages_o = out_rsv_q;

  // The search hint never points past the managed pages.
  a_hint_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hint_q <= lim)
    else $error("search hint beyond page limit");

endmodule

// ===== hw/rtl/bitmap_page_allocator_unit.sv =====
// Bitmap page allocator, next-fit search: one busy bit per page, 32 pages
// to a bitmap row held in a memory with one write and one read port, with a controller and datapath.
// An item is worked one at a time. Allocate scans rows from the search hint
// (1 to 128 rows at 4096 pages); free, lock, reserve and unreserve visit the
// rows the run spans. No row is visited when the run is empty, the kind
// undefined or allocate already at the limit. Each row costs one memory read
// and one read-modify-write step. After reset and after every write of
// total_pages a clearing pass over ceil(min(MAX_PAGES,8192)/32) rows (128 at
// the default) zeroes the bitmap, during which no item is taken.
// Depends on bpa_pkg, bpa_ctrl and bpa_dp.
module bitmap_page_allocator_unit
  import bpa_pkg::*;
#(
  parameter int unsigned MAX_PAGES = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Request items
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,   // page_index[11:0], page_count[24:12], zero
  input  logic [KIND_W-1:0] s_axis_tuser,   // kind[2:0]
  // Result items
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // alloc_page[11:0], alloc_ok[12], free_pages[25:13], used_pages[38:26],
  // reserved_pages[51:39], zero
  output logic [55:0]       m_axis_tdata,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  bpa_cmd_t         cmd;
  bpa_stat_t        stat;
  logic             cfg_wr;
  logic [CNT_W-1:0] total;
  logic [IDX_W-1:0] alloc_page;
  logic             alloc_ok;
  logic [CNT_W-1:0] free_pages, used_pages, reserved_pages;

  // Register access; writes land in the access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_TOTAL_PAGES);
  assign prdata = (paddr[2] == REG_TOTAL_PAGES) ? APB_DW'(total) : '0;

  bpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cfg_wr_i    (cfg_wr),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bpa_dp #(
    .MAX_PAGES (MAX_PAGES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_wr_i         (cfg_wr),
    .cfg_wdata_i      (pwdata[CNT_W-1:0]),
    .total_o          (total),
    .kind_i           (s_axis_tuser),
    .page_index_i     (s_axis_tdata[IDX_W-1:0]),
    .page_count_i     (s_axis_tdata[IDX_W+CNT_W-1:IDX_W]),
    .alloc_page_o     (alloc_page),
    .alloc_ok_o       (alloc_ok),
    .free_pages_o     (free_pages),
    .used_pages_o     (used_pages),
    .reserved_pages_o (reserved_pages)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata = {4'b0000, reserved_pages, used_pages, free_pages, alloc_ok, alloc_page};

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the bitmap page allocator: drives request items,
// predicts every result item from its own copy of the page map and counters,
// and reprograms the page limit between phases. Depends on bpa_pkg and the RTL.
module testbench
  import bpa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PAGE_CAP    = 4096;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned DRAIN_WAIT  = 300;
  localparam int unsigned RAND_ITEMS  = 115;
  localparam int unsigned IDX_TOP     = (1 << IDX_W) - 1;
  localparam int unsigned CNT_TOP     = (1 << CNT_W) - 1;
  localparam logic [KIND_W-1:0] KIND_FIRST_UNDEF = KIND_W'(KIND_UNRESERVE + 1);
  localparam logic [KIND_W-1:0] KIND_LAST        = '1;
  localparam logic [APB_AW-1:0] ADDR_TOTAL_PAGES = '0;
  localparam logic [APB_AW-1:0] ADDR_UNMAPPED    = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  first;
    logic [CNT_W-1:0]  count;
  } request_t;

  typedef struct packed {
    logic [IDX_W-1:0] page;
    logic             ok;
    logic [CNT_W-1:0] free_n;
    logic [CNT_W-1:0] used_n;
    logic [CNT_W-1:0] rsvd_n;
  } grant_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata = '0;   // page_index[11:0], page_count[24:12], zero
  logic [KIND_W-1:0] s_axis_tuser = '0;   // kind[2:0]
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // alloc_page[11:0], alloc_ok[12], free_pages[25:13], used_pages[38:26],
  // reserved_pages[51:39], zero
  logic [55:0]       m_axis_tdata;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  bitmap_page_allocator_unit #(
    .MAX_PAGES(PAGE_CAP)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Shadow state of the allocator.
  bit          page_busy [PAGE_CAP];
  int unsigned total_reg;
  int unsigned page_limit;
  int unsigned scan_hint;
  int unsigned free_cnt;
  int unsigned used_cnt;
  int unsigned rsvd_cnt;

  request_t    pending_q [$];
  grant_t      grant_q [$];
  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  int unsigned grants_ok = 0;
  int unsigned grants_refused = 0;
  int unsigned undef_seen = 0;
  int unsigned limit_writes = 0;
  logic        req_taken = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned cnt_up(input int unsigned c);
    return (c < CNT_MAX) ? c + 1 : c;
  endfunction

  function automatic int unsigned cnt_down(input int unsigned c);
    return (c > 0) ? c - 1 : c;
  endfunction

  // Clear the map and restart the counters for the current page limit.
  function automatic void clear_pages();
    foreach (page_busy[i]) begin
      page_busy[i] = 1'b0;
    end
    page_limit = (total_reg < PAGE_CAP) ? total_reg : PAGE_CAP;
    scan_hint  = 0;
    free_cnt   = page_limit;
    used_cnt   = 0;
    rsvd_cnt   = 0;
  endfunction

  // Apply one request to the shadow state and return the result it yields.
  function automatic grant_t apply_request(input request_t r);
    grant_t      g;
    int unsigned p;
    g.page = '0;
    g.ok   = 1'b1;
    case (r.kind)
      KIND_ALLOC: begin
        // Next-fit scan from the hint; the hint stays on the granted page.
        g.ok = 1'b0;
        while (scan_hint < page_limit && !g.ok) begin
          if (!page_busy[scan_hint]) begin
            page_busy[scan_hint] = 1'b1;
            free_cnt = cnt_down(free_cnt);
            used_cnt = cnt_up(used_cnt);
            g.page   = IDX_W'(scan_hint);
            g.ok     = 1'b1;
          end else begin
            scan_hint++;
          end
        end
      end
      KIND_FREE, KIND_UNRESERVE: begin
        for (int unsigned i = 0; i < r.count; i++) begin
          p = int'(r.first) + i;
          if (p >= page_limit) break;
          if (page_busy[p]) begin
            page_busy[p] = 1'b0;
            free_cnt = cnt_up(free_cnt);
            if (r.kind == KIND_FREE) begin
              used_cnt = cnt_down(used_cnt);
              if (scan_hint > p) scan_hint = p;
            end else begin
              rsvd_cnt = cnt_down(rsvd_cnt);
            end
          end
        end
      end
      KIND_LOCK, KIND_RESERVE: begin
        for (int unsigned i = 0; i < r.count; i++) begin
          p = int'(r.first) + i;
          if (p >= page_limit) break;
          if (!page_busy[p]) begin
            page_busy[p] = 1'b1;
            free_cnt = cnt_down(free_cnt);
            if (r.kind == KIND_LOCK) begin
              used_cnt = cnt_up(used_cnt);
            end else begin
              rsvd_cnt = cnt_up(rsvd_cnt);
            end
          end
        end
      end
      default: begin
        g.ok = 1'b0;
      end
    endcase
    g.free_n = CNT_W'(free_cnt);
    g.used_n = CNT_W'(used_cnt);
    g.rsvd_n = CNT_W'(rsvd_cnt);
    return g;
  endfunction

  // Random request, with run starts mostly inside a window of the lowest pages.
  function automatic request_t random_request(input int unsigned window);
    request_t    r;
    int unsigned pick;
    int unsigned span;
    span = (page_limit < window) ? page_limit : window;
    pick = $urandom_range(0, 99);
    if (pick < 40) r.kind = KIND_ALLOC;
    else if (pick < 58) r.kind = KIND_FREE;
    else if (pick < 68) r.kind = KIND_LOCK;
    else if (pick < 80) r.kind = KIND_RESERVE;
    else if (pick < 96) r.kind = KIND_UNRESERVE;
    else r.kind = KIND_W'($urandom_range(KIND_FIRST_UNDEF, KIND_LAST));
    if ($urandom_range(0, 9) != 0) begin
      r.first = IDX_W'($urandom_range(0, span - 1));
    end else begin
      r.first = IDX_W'($urandom_range(0, IDX_TOP));
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) r.count = '0;
    else if (pick < 75) r.count = CNT_W'($urandom_range(1, 8));
    else if (pick < 95) r.count = CNT_W'($urandom_range(9, 64));
    else r.count = CNT_W'($urandom_range(65, CNT_TOP));
    return r;
  endfunction

  task automatic queue_request(input logic [KIND_W-1:0] kind, input int unsigned first,
                               input int unsigned count);
    request_t r;
    r.kind  = kind;
    r.first = IDX_W'(first);
    r.count = CNT_W'(count);
    pending_q.push_back(r);
    items_queued++;
  endtask

  // Block until every queued item has produced its result.
  task automatic wait_drained();
    while (results_seen < items_queued) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input int unsigned data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= APB_DW'(data);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // The block is idle here, so the shadow state can follow at once.
    if (addr == ADDR_TOTAL_PAGES) begin
      total_reg = data & CNT_MAX;
      clear_pages();
      limit_writes++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_check_limit();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_TOTAL_PAGES;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== APB_DW'(total_reg)) begin
      $display("%0t total_pages read: expected %0d, actual %0d", $time, total_reg, prdata);
      errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Request driver: bursts of items separated by idle gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk_i) begin : drive_requests
    request_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !req_taken) begin
      // Hold the item until it is taken.
    end else if (gap_left > 0) begin
      s_axis_tvalid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_q.size() > 0) begin
      nxt = pending_q.pop_front();
      s_axis_tdata  <= {7'b0, nxt.count, nxt.first};
      s_axis_tuser  <= nxt.kind;
      s_axis_tvalid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Result receiver: switches at random between four stall patterns.
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned stall_tick = 0;

  always @(negedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (stall_tick % 4) != 0;
      default: m_axis_tready <= (stall_tick % 12) == 0;
    endcase
  end

  // Predict on every accepted request, then check every accepted result.
  always @(posedge clk_i) begin : score
    request_t r;
    grant_t   want;
    grant_t   got;
    if (rst_ni) begin
      req_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        r.kind  = s_axis_tuser;
        r.first = s_axis_tdata[11:0];
        r.count = s_axis_tdata[24:12];
        want = apply_request(r);
        items_taken++;
        if (r.kind == KIND_ALLOC && want.ok) grants_ok++;
        if (r.kind == KIND_ALLOC && !want.ok) grants_refused++;
        if (r.kind > KIND_UNRESERVE) undef_seen++;
        grant_q.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        got.page   = m_axis_tdata[11:0];
        got.ok     = m_axis_tdata[12];
        got.free_n = m_axis_tdata[25:13];
        got.used_n = m_axis_tdata[38:26];
        got.rsvd_n = m_axis_tdata[51:39];
        if (grant_q.size() == 0) begin
          $display("%0t result with nothing expected: actual %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = grant_q.pop_front();
          check_field("alloc_page", want.page, got.page);
          check_field("alloc_ok", want.ok, got.ok);
          check_field("free_pages", want.free_n, got.free_n);
          check_field("used_pages", want.used_n, got.used_n);
          check_field("reserved_pages", want.rsvd_n, got.rsvd_n);
        end
      end
    end
  end

  // Watchdog.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("testbench: FAIL");
    $finish;
  end

  // Stimulus sequence.
  int unsigned phase_limit [9] = '{1, 64, 4096, 37, 8, 300, 4096, 2048, 1000};

  initial begin
    int unsigned window;
    total_reg = TOTAL_RST;
    clear_pages();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    apb_check_limit();

    // Directed requests at the reset limit.
    queue_request(KIND_ALLOC, 0, 0);
    queue_request(KIND_ALLOC, 0, 0);
    queue_request(KIND_LOCK, 0, 0);
    for (int k = KIND_FIRST_UNDEF; k <= KIND_LAST; k++) begin
      queue_request(KIND_W'(k), IDX_TOP, CNT_TOP);
    end
    queue_request(KIND_LOCK, IDX_TOP, 1);
    queue_request(KIND_RESERVE, 10, 20);
    queue_request(KIND_UNRESERVE, 15, 3);
    // Unreserving a locked page: free count rises, reserved count falls.
    queue_request(KIND_UNRESERVE, IDX_TOP, 1);
    queue_request(KIND_FREE, 0, CNT_TOP);
    queue_request(KIND_RESERVE, 4000, CNT_TOP);
    queue_request(KIND_ALLOC, 0, 0);
    queue_request(KIND_LOCK, 0, PAGE_CAP);
    queue_request(KIND_ALLOC, 0, 0);
    queue_request(KIND_FREE, 2048, 1);
    queue_request(KIND_ALLOC, 0, 0);
    queue_request(KIND_ALLOC, 0, 0);
    queue_request(KIND_UNRESERVE, 0, PAGE_CAP);
    wait_drained();

    // A single managed page: exhaustion and runs beyond the limit.
    apb_write(ADDR_TOTAL_PAGES, 1);
    apb_check_limit();
    queue_request(KIND_ALLOC, 0, 0);
    queue_request(KIND_ALLOC, 0, 0);
    queue_request(KIND_LOCK, 1, 5);
    queue_request(KIND_FREE, 0, 1);
    queue_request(KIND_ALLOC, 0, 0);
    wait_drained();

    // Random phases, one page limit each.
    foreach (phase_limit[ph]) begin
      if (ph == 3) begin
        // A write to an unmapped address must leave the block alone.
        apb_write(ADDR_UNMAPPED, $urandom_range(1, PAGE_CAP));
      end
      apb_write(ADDR_TOTAL_PAGES, phase_limit[ph]);
      apb_check_limit();
      window = (phase_limit[ph] > 256) ? 256 : phase_limit[ph];
      for (int n = 0; n < RAND_ITEMS; n++) begin
        if (ph == 2 && n == RAND_ITEMS / 2) begin
          // Let the block run dry before the rest of the phase.
          wait_drained();
        end
        pending_q.push_back(random_request(window));
        items_queued++;
      end
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (grant_q.size() != 0) begin
      $display("%0t %0d results never arrived", $time, grant_q.size());
      errors++;
    end
    $display("Ran %0d request items under %0d page-limit settings, checked %0d results.",
             items_taken, limit_writes + 1, results_seen);
    $display("Allocations granted %0d, refused for lack of pages %0d, undefined kinds %0d.",
             grants_ok, grants_refused, undef_seen);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
